FILE: sv/tsef_pkg.sv
// shared types, constants and the bcd helper for the timestamped event fifo
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package tsef_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;

  // command codes
  localparam logic [1:0] CMD_LOG  = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // tens-digit and units masks of the clock registers
  localparam logic [7:0] MASK_SEC_MIN = 8'h70;
  localparam logic [7:0] MASK_HR_DATE = 8'h30;
  localparam logic [7:0] MASK_MONTH   = 8'h10;
  localparam logic [7:0] MASK_YEAR    = 8'hF0;
  localparam logic [7:0] MASK_UNITS   = 8'h0F;

  localparam int PENDING_MAX = 127;

  typedef struct packed {
    logic [1:0] cmd;
    logic       door_open;
    logic       clock_ok;
    logic [7:0] second_bcd;
    logic [7:0] minute_bcd;
    logic [7:0] hour_bcd;
    logic [7:0] date_bcd;
    logic [7:0] month_bcd;
    logic [7:0] year_bcd;
    logic       ack_received;
    logic       ack_state;
    logic       link_up;
  } in_item_t;

  typedef struct packed {
    logic       frame_valid;
    logic [7:0] frame_node;
    logic       frame_open;
    logic [5:0] frame_hour;
    logic [6:0] frame_minute;
    logic [6:0] frame_second;
    logic [5:0] frame_date;
    logic [4:0] frame_month;
    logic [7:0] frame_year;
    logic [6:0] pending;
    logic       link_down;
    logic       dropped;
  } out_item_t;

  // stored entry: door state on top of the timestamp
  typedef struct packed {
    logic [5:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
    logic [5:0] date;
    logic [4:0] month;
    logic [7:0] year;
  } tstamp_t;

  typedef struct packed {
    logic    door;
    tstamp_t ts;
  } entry_t;

  // controller commands to the datapath
  typedef struct packed {
    logic capture;
    logic log;
    logic ack;
    logic tick;
    logic nop;
  } ctl_t;

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] raw,
                                            input logic [7:0] tens_mask);
    logic [7:0] tens;
    logic [7:0] units;
    tens  = (raw & tens_mask) >> 4;
    units = raw & MASK_UNITS;
    return 8'(tens * 8'd10) + units;
  endfunction

endpackage

FILE: sv/tsef_ctrl.sv
// controller of the event fifo: takes a command beat and sequences its execution
// depends on tsef_pkg
`timescale 1ns / 1ps

module tsef_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       cmd,
  output logic             busy,
  output tsef_pkg::ctl_t   ctl
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOG  = 3'd1;
  localparam logic [2:0] ST_ACK  = 3'd2;
  localparam logic [2:0] ST_TICK = 3'd3;
  localparam logic [2:0] ST_NOP  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = ST_IDLE;
    if (accept) begin
      unique case (cmd)
        tsef_pkg::CMD_LOG:  state_nxt = ST_LOG;
        tsef_pkg::CMD_ACK:  state_nxt = ST_ACK;
        tsef_pkg::CMD_TICK: state_nxt = ST_TICK;
        default:            state_nxt = ST_NOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ctl         = '0;
    ctl.capture = accept;
    unique case (state_r)
      ST_LOG:  ctl.log  = 1'b1;
      ST_ACK:  ctl.ack  = 1'b1;
      ST_TICK: ctl.tick = 1'b1;
      ST_NOP:  ctl.nop  = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: sv/tsef_dp.sv
// datapath of the event fifo: ring memory, pointers, timestamp, link flag, result register
// depends on tsef_pkg
`timescale 1ns / 1ps

module tsef_dp #(
  parameter int QUEUE_DEPTH = tsef_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tsef_pkg::ctl_t      ctl,
  input  tsef_pkg::in_item_t  in_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  output logic                out_valid,
  output tsef_pkg::out_item_t out_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SAT_W = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  tsef_pkg::entry_t    mem [QUEUE_DEPTH];
  tsef_pkg::entry_t    rd_data_r;
  tsef_pkg::in_item_t  item_r;
  tsef_pkg::tstamp_t   ts_r, ts_nxt, ts_conv;
  tsef_pkg::out_item_t res_r, res_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SAT_W-1:0]    count_ext;
  logic                link_r, link_nxt;
  logic                valid_r;
  logic [7:0]          node_r;
  logic                wr_en;
  logic                not_empty;

  assign not_empty = (count_r != '0);

  always_comb begin
    ts_conv.second = 7'(tsef_pkg::bcd_to_bin(item_r.second_bcd, tsef_pkg::MASK_SEC_MIN));
    ts_conv.minute = 7'(tsef_pkg::bcd_to_bin(item_r.minute_bcd, tsef_pkg::MASK_SEC_MIN));
    ts_conv.hour   = 6'(tsef_pkg::bcd_to_bin(item_r.hour_bcd, tsef_pkg::MASK_HR_DATE));
    ts_conv.date   = 6'(tsef_pkg::bcd_to_bin(item_r.date_bcd, tsef_pkg::MASK_HR_DATE));
    ts_conv.month  = 5'(tsef_pkg::bcd_to_bin(item_r.month_bcd, tsef_pkg::MASK_MONTH));
    ts_conv.year   = tsef_pkg::bcd_to_bin(item_r.year_bcd, tsef_pkg::MASK_YEAR);
  end

  always_comb begin
    ts_nxt    = ts_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    link_nxt  = link_r;
    wr_en     = 1'b0;
    res_nxt   = '0;

    if (ctl.log) begin
      if (item_r.clock_ok) begin
        ts_nxt = ts_conv;
      end
      if (count_r != CNT_FULL) begin
        wr_en     = 1'b1;
        tail_nxt  = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
        count_nxt = count_r + 1'b1;
      end else begin
        res_nxt.dropped = 1'b1;
      end
    end

    if (ctl.ack && item_r.ack_received && not_empty &&
        (rd_data_r.door == item_r.ack_state)) begin
      head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end

    if (ctl.tick) begin
      link_nxt = !item_r.link_up;
      if (item_r.link_up && not_empty) begin
        res_nxt.frame_valid  = 1'b1;
        res_nxt.frame_node   = node_r;
        res_nxt.frame_open   = rd_data_r.door;
        res_nxt.frame_hour   = rd_data_r.ts.hour;
        res_nxt.frame_minute = rd_data_r.ts.minute;
        res_nxt.frame_second = rd_data_r.ts.second;
        res_nxt.frame_date   = rd_data_r.ts.date;
        res_nxt.frame_month  = rd_data_r.ts.month;
        res_nxt.frame_year   = rd_data_r.ts.year;
      end
    end

    // pending saturates at the width of the result field
    count_ext = SAT_W'(count_nxt);
    res_nxt.pending   = (count_ext > SAT_W'(tsef_pkg::PENDING_MAX)) ?
                        7'(tsef_pkg::PENDING_MAX) : count_ext[6:0];
    res_nxt.link_down = link_nxt;
  end

  // ring memory, head entry read every cycle into a register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= {item_r.door_open, ts_nxt};
    end
    rd_data_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_r <= in_item;
    end
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r    <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      link_r  <= 1'b1;
      valid_r <= 1'b0;
      node_r  <= '0;
    end else begin
      ts_r    <= ts_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      link_r  <= link_nxt;
      valid_r <= ctl.log || ctl.ack || ctl.tick || ctl.nop;
      if (cfg_we) begin
        node_r <= cfg_data;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_item  = res_r;

endmodule

FILE: sv/timestamped_event_fifo_with_ack_core.sv
// top level of the timestamped event fifo: controller plus datapath
// depends on tsef_pkg, tsef_ctrl, tsef_dp
// the accepting edge loads state_r and item_r; out_valid and the result are then registered from the execute state
// a new beat is accepted only while busy is low, so not during the execute state that follows each accept
// out_valid is high for one cycle per beat; the receiver cannot stall
// reset is synchronous active low: queue empty, timestamp zero, link down, node id zero
`timescale 1ns / 1ps

module timestamped_event_fifo_with_ack_core #(
  parameter int QUEUE_DEPTH = tsef_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tsef_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tsef_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  tsef_pkg::ctl_t ctl;

  // the node id register takes a write in any cycle
  assign cfg_ready = 1'b1;

  tsef_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cmd   (in_item.cmd),
    .busy  (busy),
    .ctl   (ctl)
  );

  tsef_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
